// ----- rtl/fpc_pkg.sv -----
// Package with shared types and constants for the file permission checker.
`timescale 1ns / 1ps
`default_nettype none

package fpc_pkg;

  // Width of every principal and group id.
  localparam int unsigned IdW = 32;

  // Group id that never counts as membership.
  localparam logic [IdW-1:0] BadGroup = '1;

  // Capability flag bit positions.
  localparam int unsigned CapHost  = 0;
  localparam int unsigned CapDac   = 1;
  localparam int unsigned CapChown = 2;

  // Wanted access bit positions (rwx order).
  localparam int unsigned WantR = 2;
  localparam int unsigned WantW = 1;
  localparam int unsigned WantX = 0;

  // Handle rights bit positions.
  localparam int unsigned RightR = 0;
  localparam int unsigned RightW = 1;

  // Open mode truncate bit position.
  localparam int unsigned OpenTrunc = 4;

  // Change mask bit positions.
  localparam int unsigned ChgMode  = 0;
  localparam int unsigned ChgOwner = 1;
  localparam int unsigned ChgGroup = 2;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_PRINCIPAL = 3'd0,
    REG_PRIMARY   = 3'd1,
    REG_CAPS      = 3'd2,
    REG_COUNT     = 3'd3,
    REG_PAIR_A    = 3'd4,
    REG_PAIR_B    = 3'd5,
    REG_PAIR_C    = 3'd6,
    REG_PAIR_D    = 3'd7
  } fpc_reg_e;

  // Request actions.
  typedef enum logic [1:0] {
    ACT_ACCESS = 2'd0,
    ACT_OPEN   = 2'd1,
    ACT_CHANGE = 2'd2
  } fpc_action_e;

  // Open mode access kinds, taken from the two low bits.
  typedef enum logic [1:0] {
    OM_READ      = 2'd0,
    OM_WRITE     = 2'd1,
    OM_READWRITE = 2'd2,
    OM_EXEC      = 2'd3
  } fpc_open_e;

  // One request transaction.
  typedef struct packed {
    logic [1:0]     action;
    logic [IdW-1:0] file_owner;
    logic [IdW-1:0] file_group;
    logic [8:0]     file_mode;
    logic [2:0]     want_bits;
    logic [7:0]     open_mode;
    logic [2:0]     change_mask;
    logic [IdW-1:0] target_group;
  } fpc_req_t;

  // One result transaction.
  typedef struct packed {
    logic       allowed;
    logic [1:0] granted_rights;
  } fpc_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/fpc_req_if.sv -----
// Valid/ready channel interface that carries request transactions.
`timescale 1ns / 1ps
`default_nettype none

interface fpc_req_if
  import fpc_pkg::*;
();
  logic     valid;
  logic     ready;
  fpc_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/fpc_rsp_if.sv -----
// Valid/ready channel interface that carries result transactions.
`timescale 1ns / 1ps
`default_nettype none

interface fpc_rsp_if
  import fpc_pkg::*;
();
  logic     valid;
  logic     ready;
  fpc_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/file_permission_checker.sv -----
// Top level of the file permission checker: register file, check logic and result stage.
// A request is held in the input register while it is checked, and its result is registered in the result register.
// Throughput: one request per cycle while results are taken; the group compares run in parallel in one stage.
// A result waiting at the output does not block intake while the input register is free.
// Reset clears the valid flags and loads the credential registers with their reset values.
`timescale 1ns / 1ps
`default_nettype none

module file_permission_checker
  import fpc_pkg::*;
#(
  parameter int unsigned SUPP_GROUPS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  fpc_req_if.sink          req_i,
  fpc_rsp_if.source        rsp_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready
);

  localparam logic [3:0] SuppCnt = 4'(SUPP_GROUPS);

  // Credential registers.
  logic [IdW-1:0] principal_q;
  logic [IdW-1:0] primary_q;
  logic [2:0]     caps_q;
  logic [3:0]     count_q;
  logic [IdW-1:0] grp_q [SUPP_GROUPS];

  logic     cfg_wr;
  fpc_reg_e cfg_idx;

  // Pipeline registers.
  logic     s1_valid_q;
  fpc_req_t s1_req_q;
  logic     out_valid_q;
  fpc_rsp_t out_rsp_q;
  fpc_rsp_t rsp_d;
  logic     advance_out;
  logic     s1_ready;

  // Check logic signals.
  logic [3:0]       cnt_eff;
  logic             file_member;
  logic             tgt_member;
  logic             is_owner;
  logic             bypass;
  logic             chown_cap;
  logic [2:0]       open_want;
  logic [1:0]       open_rights;
  logic [2:0]       check_want;
  logic [2:0]       class_bits;
  logic             access_ok;
  logic             change_ok;

  // APB decode: writes complete in the access phase, no wait states.
  assign pready  = 1'b1;
  assign cfg_idx = fpc_reg_e'(paddr[5:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Credential register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      principal_q <= '0;
      primary_q   <= BadGroup;
      caps_q      <= '0;
      count_q     <= '0;
      for (int k = 0; k < SUPP_GROUPS; k++) begin
        grp_q[k] <= BadGroup;
      end
    end else if (cfg_wr) begin
      if (cfg_idx == REG_PRINCIPAL) begin
        principal_q <= pwdata[IdW-1:0];
      end
      if (cfg_idx == REG_PRIMARY) begin
        primary_q <= pwdata[IdW-1:0];
      end
      if (cfg_idx == REG_CAPS) begin
        caps_q <= pwdata[2:0];
      end
      if (cfg_idx == REG_COUNT) begin
        count_q <= pwdata[3:0];
      end
      for (int k = 0; k < SUPP_GROUPS; k++) begin
        if (paddr[5:3] == 3'(int'(REG_PAIR_A) + (k >> 1))) begin
          grp_q[k] <= ((k & 1) != 0) ? pwdata[63:32] : pwdata[31:0];
        end
      end
    end
  end

  // Register readback; group slots beyond the table read as the invalid id.
  always_comb begin
    logic [IdW-1:0] lo;
    logic [IdW-1:0] hi;
    lo = BadGroup;
    hi = BadGroup;
    for (int k = 0; k < SUPP_GROUPS; k++) begin
      if (paddr[5:3] == 3'(int'(REG_PAIR_A) + (k >> 1))) begin
        if ((k & 1) != 0) begin
          hi = grp_q[k];
        end else begin
          lo = grp_q[k];
        end
      end
    end
    unique case (cfg_idx)
      REG_PRINCIPAL: prdata = {32'd0, principal_q};
      REG_PRIMARY:   prdata = {32'd0, primary_q};
      REG_CAPS:      prdata = {61'd0, caps_q};
      REG_COUNT:     prdata = {60'd0, count_q};
      default:       prdata = {hi, lo};
    endcase
  end

  // Handshake: the output register frees when empty or taken, the input register follows.
  assign advance_out = !out_valid_q || rsp_o.ready;
  assign s1_ready    = !s1_valid_q || advance_out;
  assign req_i.ready = s1_ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && req_i.valid) begin
      s1_req_q <= req_i.data;
    end
  end

  // Group membership of the file group and the target group, compared in parallel.
  assign cnt_eff = (count_q > SuppCnt) ? SuppCnt : count_q;

  always_comb begin
    logic file_hit;
    logic tgt_hit;
    file_hit = 1'b0;
    tgt_hit  = 1'b0;
    for (int k = 0; k < SUPP_GROUPS; k++) begin
      if (4'(k) < cnt_eff) begin
        if (grp_q[k] == s1_req_q.file_group) begin
          file_hit = 1'b1;
        end
        if (grp_q[k] == s1_req_q.target_group) begin
          tgt_hit = 1'b1;
        end
      end
    end
    file_member = (s1_req_q.file_group != BadGroup) &&
                  ((s1_req_q.file_group == primary_q) || file_hit);
    tgt_member  = (s1_req_q.target_group != BadGroup) &&
                  ((s1_req_q.target_group == primary_q) || tgt_hit);
  end

  assign is_owner  = (principal_q == s1_req_q.file_owner);
  assign bypass    = caps_q[CapHost] || caps_q[CapDac];
  assign chown_cap = caps_q[CapHost] || caps_q[CapChown];

  // Wanted set and handle rights derived from the open mode.
  always_comb begin
    unique case (fpc_open_e'(s1_req_q.open_mode[1:0]))
      OM_READ: begin
        open_want   = 3'(1 << WantR);
        open_rights = 2'(1 << RightR);
      end
      OM_WRITE: begin
        open_want   = 3'(1 << WantW);
        open_rights = 2'(1 << RightW);
      end
      OM_READWRITE: begin
        open_want   = 3'((1 << WantR) | (1 << WantW));
        open_rights = 2'((1 << RightR) | (1 << RightW));
      end
      default: begin
        open_want   = 3'((1 << WantR) | (1 << WantX));
        open_rights = 2'(1 << RightR);
      end
    endcase
    if (s1_req_q.open_mode[OpenTrunc]) begin
      open_want[WantW]    = 1'b1;
      open_rights[RightW] = 1'b1;
    end
  end

  // Owner-first class selection and the rwx check.
  assign check_want = (s1_req_q.action == ACT_OPEN) ? open_want : s1_req_q.want_bits;

  always_comb begin
    priority if (is_owner) begin
      class_bits = s1_req_q.file_mode[8:6];
    end else if (file_member) begin
      class_bits = s1_req_q.file_mode[5:3];
    end else begin
      class_bits = s1_req_q.file_mode[2:0];
    end
  end

  assign access_ok = bypass || ((class_bits & check_want) == check_want);

  // Attribute change rules.
  assign change_ok =
      (!s1_req_q.change_mask[ChgMode] || is_owner || caps_q[CapHost]) &&
      (!s1_req_q.change_mask[ChgOwner] || chown_cap) &&
      (!s1_req_q.change_mask[ChgGroup] || chown_cap || (is_owner && tgt_member));

  // Result selection by action.
  always_comb begin
    rsp_d = '0;
    unique case (fpc_action_e'(s1_req_q.action))
      ACT_ACCESS: rsp_d.allowed = access_ok;
      ACT_OPEN: begin
        rsp_d.allowed        = access_ok;
        rsp_d.granted_rights = open_rights;
      end
      ACT_CHANGE: rsp_d.allowed = change_ok;
      default:    rsp_d = '0;
    endcase
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance_out) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_out && s1_valid_q) begin
      out_rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_rsp_q;

  // Intake stalls only when both pipeline registers are full and the output is held.
  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !req_i.ready |-> (s1_valid_q && out_valid_q && !rsp_o.ready))
    else $error("request intake stalled while the pipeline had room");

  // Only an open check grants handle rights.
  a_rights_only_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (s1_valid_q && advance_out && s1_req_q.action != ACT_OPEN)
      |=> (rsp_o.data.granted_rights == 2'd0))
    else $error("handle rights granted by an action other than open");

  // An unused action code is always denied.
  a_unused_action_denied: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (s1_valid_q && advance_out && s1_req_q.action != ACT_OPEN &&
       s1_req_q.action != ACT_ACCESS && s1_req_q.action != ACT_CHANGE)
      |=> !rsp_o.data.allowed)
    else $error("unused action code was allowed");

  // Host-owner or override capability always passes an access or open check.
  a_bypass_allows: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (s1_valid_q && advance_out && bypass &&
       (s1_req_q.action == ACT_ACCESS || s1_req_q.action == ACT_OPEN))
      |=> rsp_o.data.allowed)
    else $error("capability bypass did not allow the access");

endmodule

`default_nettype wire
